/* hdl/cdq_pkg.sv */
`default_nettype none

package cdq_pkg;

	// data word width
	localparam int unsigned WORD_W = 32;

	// operation codes
	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_REAR  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	// per-cell move selection
	typedef enum logic [1:0] {
		CM_HOLD = 2'd0,
		CM_SHR  = 2'd1,
		CM_ROL  = 2'd2
	} cell_mode_t;

	// control handed to each cell
	typedef struct packed {
		cell_mode_t mode;
		logic       wr;
	} cell_ctrl_t;

	// controller states
	typedef enum logic {
		FS_IDLE = 1'b0,
		FS_SCAN = 1'b1
	} fsm_t;

	// one result word
	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		status_t                  status;
		logic                     empty;
		logic                     full;
	} res_t;

endpackage

`default_nettype wire

/* hdl/cdq_cell.sv */
`default_nettype none

module cdq_cell (
	input  wire logic                                  clk,
	input  wire cdq_pkg::cell_ctrl_t                   ctrl,
	input  wire logic signed [cdq_pkg::WORD_W-1:0]     from_left,
	input  wire logic signed [cdq_pkg::WORD_W-1:0]     from_right,
	input  wire logic signed [cdq_pkg::WORD_W-1:0]     wr_data,
	output logic signed [cdq_pkg::WORD_W-1:0]          q
);

	logic signed [cdq_pkg::WORD_W-1:0] data_q;

	// local write wins, otherwise move with the chain
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			data_q <= wr_data;
		end else begin
			case (ctrl.mode)
				cdq_pkg::CM_SHR: begin
					data_q <= from_left;
				end
				cdq_pkg::CM_ROL: begin
					data_q <= from_right;
				end
				default: begin
					data_q <= data_q;
				end
			endcase
		end
	end

	assign q = data_q;

endmodule

`default_nettype wire

/* hdl/circular_deque.sv */
`default_nettype none

// Double-ended queue of up to DEPTH signed 32-bit words held in a ring of
// identical cells; the front element always sits in cell 0. Push front,
// push rear and pop front are each handled when accepted: the ring shifts
// right, one cell loads the word, or the ring rotates left by one. Pop rear
// is accepted and then turns the ring once in full, one cell per cycle,
// during which the rear word passes cell 0 and is caught; the ring stands
// as before once the turn is done. Every operation gives one result word
// (popped data, status, empty and full flags after the operation). Pushes
// onto a full deque are dropped with an overflow status, pops from an empty
// deque return zero with an underflow status. A two-entry output stage lets
// a new operation be taken while one result is still stalled.
module circular_deque #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [1:0]                         op,
	input  wire logic signed [cdq_pkg::WORD_W-1:0]  in_data,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [cdq_pkg::WORD_W-1:0]       out_data,
	output logic [1:0]                              status,
	output logic                                    is_empty,
	output logic                                    is_full
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] K_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cdq_pkg::fsm_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [IDX_W-1:0] k_q;
	logic signed [cdq_pkg::WORD_W-1:0] cap_q;

	cdq_pkg::res_t out_q, skid_q, prod_res;
	logic out_valid_q, skid_valid_q;
	logic prod, accept, out_take, wr_rear, hit;
	cdq_pkg::cell_mode_t mode;
	cdq_pkg::op_t op_w;

	logic signed [cdq_pkg::WORD_W-1:0] cell_q [DEPTH];
	cdq_pkg::cell_ctrl_t cell_ctrl [DEPTH];

	assign op_w = cdq_pkg::op_t'(op);
	assign accept = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;
	assign hit = ({{(CNT_W-IDX_W){1'b0}}, k_q} == (count_q - CNT_W'(1)));

	// ring of cells
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [cdq_pkg::WORD_W-1:0] left_w, right_w;

		if (i == 0) begin : g_first
			assign left_w = in_data;
		end else begin : g_mid_l
			assign left_w = cell_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_q[0];
		end else begin : g_mid_r
			assign right_w = cell_q[i+1];
		end

		assign cell_ctrl[i].mode = mode;
		assign cell_ctrl[i].wr = wr_rear && (count_q == CNT_W'(i));

		cdq_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl[i]),
			.from_left  (left_w),
			.from_right (right_w),
			.wr_data    (in_data),
			.q          (cell_q[i])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cdq_pkg::FS_IDLE: begin
				if (accept && op_w == cdq_pkg::OP_POP_REAR && count_q != '0) begin
					state_d = cdq_pkg::FS_SCAN;
				end
			end
			cdq_pkg::FS_SCAN: begin
				if (k_q == K_LAST) begin
					state_d = cdq_pkg::FS_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::FS_IDLE;
			end
		endcase
	end

	// controller outputs and result word
	always_comb begin
		in_stall = 1'b1;
		mode = cdq_pkg::CM_HOLD;
		wr_rear = 1'b0;
		prod = 1'b0;
		count_d = count_q;
		prod_res.data = '0;
		prod_res.status = cdq_pkg::ST_OK;
		case (state_q)
			cdq_pkg::FS_IDLE: begin
				in_stall = skid_valid_q;
				if (accept) begin
					case (op_w)
						cdq_pkg::OP_PUSH_FRONT, cdq_pkg::OP_PUSH_REAR: begin
							prod = 1'b1;
							if (count_q == CNT_FULL) begin
								prod_res.status = cdq_pkg::ST_OVERFLOW;
							end else begin
								count_d = count_q + CNT_W'(1);
								if (op_w == cdq_pkg::OP_PUSH_FRONT) begin
									mode = cdq_pkg::CM_SHR;
								end else begin
									wr_rear = 1'b1;
								end
							end
						end
						cdq_pkg::OP_POP_FRONT: begin
							prod = 1'b1;
							if (count_q == '0) begin
								prod_res.status = cdq_pkg::ST_UNDERFLOW;
							end else begin
								prod_res.data = cell_q[0];
								count_d = count_q - CNT_W'(1);
								mode = cdq_pkg::CM_ROL;
							end
						end
						default: begin
							// pop rear: refuse at once or start the ring turn
							if (count_q == '0) begin
								prod = 1'b1;
								prod_res.status = cdq_pkg::ST_UNDERFLOW;
							end
						end
					endcase
				end
			end
			cdq_pkg::FS_SCAN: begin
				mode = cdq_pkg::CM_ROL;
				if (k_q == K_LAST) begin
					prod = 1'b1;
					prod_res.data = hit ? cell_q[0] : cap_q;
					count_d = count_q - CNT_W'(1);
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		prod_res.empty = (count_d == '0);
		prod_res.full = (count_d == CNT_FULL);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::FS_IDLE;
			count_q <= '0;
			k_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == cdq_pkg::FS_SCAN) begin
				k_q <= (k_q == K_LAST) ? '0 : k_q + IDX_W'(1);
			end
		end
	end

	// rear word catch during the ring turn
	always_ff @(posedge clk) begin
		if (state_q == cdq_pkg::FS_SCAN && hit) begin
			cap_q <= cell_q[0];
		end
	end

	// output register and skid entry, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_take) begin
				if (skid_valid_q) begin
					out_valid_q <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= prod;
				end
			end else if (prod) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_take) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (prod) begin
				out_q <= prod_res;
			end
		end else if (prod) begin
			skid_q <= prod_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q.data;
	assign status = out_q.status;
	assign is_empty = out_q.empty;
	assign is_full = out_q.full;

	// a new word never meets a full skid entry
	a_no_skid_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(skid_valid_q && prod))
		else $error("result produced while skid entry full");

	// element count stays within the ring
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("element count beyond depth");

	// a rear pop on a non-empty deque starts the ring turn
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && op_w == cdq_pkg::OP_POP_REAR && count_q != '0)
		|=> (state_q == cdq_pkg::FS_SCAN && k_q == '0))
		else $error("rear pop did not start ring turn");

	// the turn ends with exactly one result and one element less
	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cdq_pkg::FS_SCAN && k_q == K_LAST)
		|=> (state_q == cdq_pkg::FS_IDLE && count_q == $past(count_q) - CNT_W'(1)))
		else $error("ring turn did not close correctly");

endmodule

`default_nettype wire

/* tb/circular_deque_tb.sv */
`timescale 1ns / 100ps

module circular_deque_tb;

	localparam int unsigned DEPTH   = 16;
	localparam int unsigned PW      = $clog2(DEPTH);
	localparam int unsigned N_RAND  = 500;
	localparam int unsigned QUIET_MAX = 2000;
	localparam int unsigned N_DIR   = 25;

	// one row of the directed table
	typedef struct packed {
		cdq_pkg::op_t                      op;
		logic signed [cdq_pkg::WORD_W-1:0] word;
		logic                              has_want;
		cdq_pkg::res_t                     want;
	} dir_row_t;

	logic                              clk;
	logic                              arst_n   = 1'b0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic [1:0]                        op       = cdq_pkg::OP_PUSH_FRONT;
	logic signed [cdq_pkg::WORD_W-1:0] in_data  = '0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [cdq_pkg::WORD_W-1:0] out_data;
	logic [1:0]                        status;
	logic                              is_empty;
	logic                              is_full;

	// idle percentages of the current phase
	int unsigned tx_idle = 8;
	int unsigned rx_idle = 55;

	// fixed expectation travelling with the word on the input side
	logic          cur_has_want = 1'b0;
	cdq_pkg::res_t cur_want     = '0;

	// deque shadow state
	logic signed [cdq_pkg::WORD_W-1:0] dq_slot [DEPTH];
	logic [PW-1:0]                     dq_head = '0;
	logic [PW-1:0]                     dq_tail = '0;
	logic                              dq_empty = 1'b1;

	cdq_pkg::res_t pending_res [$];
	cdq_pkg::res_t pred_res;
	cdq_pkg::res_t got_res;
	int unsigned errors    = 0;
	int unsigned n_sent    = 0;
	int unsigned n_checked = 0;
	int unsigned n_over    = 0;
	int unsigned n_under   = 0;
	int unsigned n_full    = 0;
	int unsigned quiet     = 0;

	dir_row_t dir_tab [N_DIR] = '{
		// pops right after reset underflow
		'{cdq_pkg::OP_POP_FRONT, 32'sh00000000, 1'b1,
			'{32'sh0, cdq_pkg::ST_UNDERFLOW, 1'b1, 1'b0}},
		'{cdq_pkg::OP_POP_REAR, 32'sh00000000, 1'b1,
			'{32'sh0, cdq_pkg::ST_UNDERFLOW, 1'b1, 1'b0}},
		// extremes pushed at both ends, then popped, last pop empties
		'{cdq_pkg::OP_PUSH_REAR, 32'sh7fffffff, 1'b1,
			'{32'sh0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_PUSH_FRONT, 32'sh80000000, 1'b1,
			'{32'sh0, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_REAR, 32'sh00000000, 1'b1,
			'{32'sh7fffffff, cdq_pkg::ST_OK, 1'b0, 1'b0}},
		'{cdq_pkg::OP_POP_FRONT, 32'sh00000000, 1'b1,
			'{32'sh80000000, cdq_pkg::ST_OK, 1'b1, 1'b0}},
		// fill from both ends so the pointers wrap
		'{cdq_pkg::OP_PUSH_FRONT, 32'shffffffff, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'sh00000000, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh55555555, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shaaaaaaaa, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh00000001, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shfffffffe, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh7fffffff, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'sh80000000, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh12345678, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shedcba987, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh0f0f0f0f, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shf0f0f0f0, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh33333333, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shcccccccc, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_REAR,  32'sh00ff00ff, 1'b0, '0},
		'{cdq_pkg::OP_PUSH_FRONT, 32'shff00ff00, 1'b0, '0},
		// push onto a full deque is dropped
		'{cdq_pkg::OP_PUSH_REAR, 32'sh5a5a5a5a, 1'b1,
			'{32'sh0, cdq_pkg::ST_OVERFLOW, 1'b0, 1'b1}},
		'{cdq_pkg::OP_POP_REAR,   32'sh00000000, 1'b0, '0},
		'{cdq_pkg::OP_POP_FRONT,  32'sh00000000, 1'b0, '0}
	};

	circular_deque #(
		.DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.op       (op),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.status   (status),
		.is_empty (is_empty),
		.is_full  (is_full)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
		return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
	endfunction

	// apply one operation to the shadow deque and give its result word
	function automatic cdq_pkg::res_t deque_step(input cdq_pkg::op_t o,
			input logic signed [cdq_pkg::WORD_W-1:0] w);
		cdq_pkg::res_t r;
		r.data   = '0;
		r.status = cdq_pkg::ST_OK;
		if (o == cdq_pkg::OP_PUSH_FRONT || o == cdq_pkg::OP_PUSH_REAR) begin
			if (!dq_empty && dq_head == ring_next(dq_tail)) begin
				r.status = cdq_pkg::ST_OVERFLOW;
			end else if (dq_empty) begin
				// first element always lands in slot zero
				dq_head    = '0;
				dq_tail    = '0;
				dq_empty   = 1'b0;
				dq_slot[0] = w;
			end else if (o == cdq_pkg::OP_PUSH_FRONT) begin
				dq_head          = ring_prev(dq_head);
				dq_slot[dq_head] = w;
			end else begin
				dq_tail          = ring_next(dq_tail);
				dq_slot[dq_tail] = w;
			end
		end else begin
			if (dq_empty) begin
				r.status = cdq_pkg::ST_UNDERFLOW;
			end else begin
				r.data = (o == cdq_pkg::OP_POP_FRONT) ? dq_slot[dq_head] : dq_slot[dq_tail];
				if (dq_head == dq_tail) begin
					// last element gone, pointers back home
					dq_head  = '0;
					dq_tail  = '0;
					dq_empty = 1'b1;
				end else if (o == cdq_pkg::OP_POP_FRONT) begin
					dq_head = ring_next(dq_head);
				end else begin
					dq_tail = ring_prev(dq_tail);
				end
			end
		end
		r.empty = dq_empty;
		r.full  = !dq_empty && dq_head == ring_next(dq_tail);
		return r;
	endfunction

	// input side: predict on every accepted word
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			pred_res = deque_step(cdq_pkg::op_t'(op), in_data);
			pending_res.push_back(cur_has_want ? cur_want : pred_res);
		end
	end

	// output side: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (status == cdq_pkg::ST_OVERFLOW) n_over++;
			if (status == cdq_pkg::ST_UNDERFLOW) n_under++;
			if (is_full) n_full++;
			if (pending_res.size() == 0) begin
				$display("%0t: result word with nothing expected: data %0d status %0d",
					$time, out_data, status);
				errors++;
			end else begin
				got_res = pending_res.pop_front();
				if (out_data !== got_res.data) begin
					$display("%0t: out_data expected %0d got %0d", $time, got_res.data, out_data);
					errors++;
				end
				if (status !== got_res.status) begin
					$display("%0t: status expected %0d got %0d", $time, got_res.status, status);
					errors++;
				end
				if (is_empty !== got_res.empty) begin
					$display("%0t: is_empty expected %0b got %0b", $time, got_res.empty, is_empty);
					errors++;
				end
				if (is_full !== got_res.full) begin
					$display("%0t: is_full expected %0b got %0b", $time, got_res.full, is_full);
					errors++;
				end
			end
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		out_stall <= (rx_idle != 0) && ($urandom_range(99) < rx_idle);
	end

	// count cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		wait (quiet >= QUIET_MAX);
		$display("%0t: no handshake for %0d cycles", $time, QUIET_MAX);
		$display("FAILURE");
		$finish;
	end

	// present one word and hold it until taken; called at a falling edge
	task automatic send_word(input cdq_pkg::op_t o, input logic signed [cdq_pkg::WORD_W-1:0] w,
			input logic has, input cdq_pkg::res_t want);
		while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		op           <= o;
		in_data      <= w;
		cur_has_want <= has;
		cur_want     <= want;
		do @(posedge clk); while (in_stall);
		n_sent++;
		@(negedge clk);
	endtask

	initial begin
		int unsigned push_pct;
		cdq_pkg::op_t r_op;
		logic signed [cdq_pkg::WORD_W-1:0] r_word;

		// hold reset, then release it at a falling edge
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			send_word(dir_tab[i].op, dir_tab[i].word, dir_tab[i].has_want, dir_tab[i].want);
		end

		// random traffic in three idle phases
		for (int ph = 0; ph < 3; ph++) begin
			tx_idle = (ph == 0) ? 8 : (ph == 1) ? 55 : 0;
			rx_idle = (ph == 0) ? 55 : (ph == 1) ? 8 : 0;
			push_pct = 50;
			for (int n = 0; n < N_RAND; n++) begin
				// bursts lean towards filling, draining or balance
				if (n % 32 == 0) begin
					case ($urandom_range(2))
						0: push_pct = 15;
						1: push_pct = 50;
						default: push_pct = 85;
					endcase
				end
				if ($urandom_range(99) < push_pct) begin
					r_op = $urandom_range(1) ? cdq_pkg::OP_PUSH_REAR : cdq_pkg::OP_PUSH_FRONT;
				end else begin
					r_op = $urandom_range(1) ? cdq_pkg::OP_POP_REAR : cdq_pkg::OP_POP_FRONT;
				end
				if ($urandom_range(9) == 0) begin
					case ($urandom_range(3))
						0: r_word = 32'sh7fffffff;
						1: r_word = 32'sh80000000;
						2: r_word = 32'sh00000000;
						default: r_word = 32'shffffffff;
					endcase
				end else begin
					r_word = $urandom;
				end
				send_word(r_op, r_word, 1'b0, '0);
			end
		end
		in_valid <= 1'b0;

		// drain, then allow for a late extra word
		while (pending_res.size() != 0) @(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("sent %0d operations, checked %0d results", n_sent, n_checked);
		$display("seen %0d overflows, %0d underflows, %0d full flags, %0d errors",
			n_over, n_under, n_full, errors);
		if (errors == 0 && pending_res.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

/* filelist.f */
hdl/cdq_pkg.sv
hdl/cdq_cell.sv
hdl/circular_deque.sv
tb/circular_deque_tb.sv
